/* hdl/emh_pkg.sv */
package emh_pkg;

   localparam int CAPACITY   = 1024;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int TIME_BITS  = 48;
   localparam int KIND_BITS  = 4;
   localparam int ENTRY_BITS = TIME_BITS + KIND_BITS;
   localparam int STAT_BITS  = 2;

   // operation codes (req_tuser)
   localparam logic FUNC_INSERT  = 1'b0;
   localparam logic FUNC_EXTRACT = 1'b1;

   // status codes (rsp_tuser)
   localparam logic [STAT_BITS-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_BITS-1:0] ST_EXTRACTED = 2'd2;
   localparam logic [STAT_BITS-1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [TIME_BITS-1:0] time_val;
      logic [KIND_BITS-1:0] kind;
   } entry_type;

   // operand pairing of the shared comparator
   typedef enum logic [1:0] {
      CMP_UP    = 2'd0,   // new item vs parent
      CMP_LEFT  = 2'd1,   // left child vs moving item
      CMP_RIGHT = 2'd2    // right child vs best so far
   } cmp_sel_type;

   typedef struct packed {
      logic                  valid;
      logic [STAT_BITS-1:0]  status;
      logic [TIME_BITS-1:0]  out_time;
      logic [KIND_BITS-1:0]  out_kind;
      logic [CNT_BITS-1:0]   entry_count;
   } result_type;

endpackage

/* hdl/emh_ram.sv */
module emh_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [emh_pkg::ADDR_BITS-1:0]     wr_addr,
   input  emh_pkg::entry_type                wr_data,
   input  logic [emh_pkg::ADDR_BITS-1:0]     rd_addr_a,
   input  logic [emh_pkg::ADDR_BITS-1:0]     rd_addr_b,
   output emh_pkg::entry_type                rd_data_a,
   output emh_pkg::entry_type                rd_data_b
);

   emh_pkg::entry_type mem [emh_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

/* hdl/emh_cmp.sv */
module emh_cmp (
   input  emh_pkg::cmp_sel_type  sel,
   input  emh_pkg::entry_type    item,
   input  emh_pkg::entry_type    best,
   input  emh_pkg::entry_type    rd_a,
   input  emh_pkg::entry_type    rd_b,
   output logic                  less
);

   logic [emh_pkg::TIME_BITS-1:0] op_a;
   logic [emh_pkg::TIME_BITS-1:0] op_b;

   always_comb begin
      unique case (sel)
         emh_pkg::CMP_UP: begin
            op_a = item.time_val;
            op_b = rd_a.time_val;
         end
         emh_pkg::CMP_LEFT: begin
            op_a = rd_a.time_val;
            op_b = item.time_val;
         end
         emh_pkg::CMP_RIGHT: begin
            op_a = rd_b.time_val;
            op_b = best.time_val;
         end
         default: begin
            op_a = rd_a.time_val;
            op_b = item.time_val;
         end
      endcase
   end

   assign less = op_a < op_b;

endmodule

/* hdl/emh_seq.sv */
module emh_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_func,
   input  emh_pkg::entry_type                req_entry,
   output emh_pkg::result_type               res,
   input  logic                              res_take
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_UP_RD    = 9'b000000010,
      S_UP_CMP   = 9'b000000100,
      S_X_RD     = 9'b000001000,
      S_X_GET    = 9'b000010000,
      S_DN_RD    = 9'b000100000,
      S_DN_LEFT  = 9'b001000000,
      S_DN_RIGHT = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   localparam int AB = emh_pkg::ADDR_BITS;
   localparam int CB = emh_pkg::CNT_BITS;

   state_type                         state_ff, state_in;
   logic [CB-1:0]                     fill_ff, fill_in;
   logic [AB-1:0]                     pos_ff, pos_in;
   emh_pkg::entry_type                item_ff, item_in;
   emh_pkg::entry_type                best_ff, best_in;
   logic                              best_lc_ff, best_lc_in;
   logic [emh_pkg::STAT_BITS-1:0]     status_ff, status_in;
   emh_pkg::entry_type                out_ff, out_in;

   logic [AB-1:0]                     pos_m1;
   logic [AB-1:0]                     par_addr;
   logic [CB:0]                       lc_idx;
   logic [CB:0]                       rc_idx;
   logic                              lc_ok;
   logic                              rc_ok;
   logic                              accept;
   logic                              less;
   emh_pkg::cmp_sel_type              cmp_sel;

   logic                              wr_en;
   logic [AB-1:0]                     wr_addr;
   emh_pkg::entry_type                wr_data;
   logic [AB-1:0]                     rd_addr_a;
   logic [AB-1:0]                     rd_addr_b;
   emh_pkg::entry_type                rd_data_a;
   emh_pkg::entry_type                rd_data_b;

   assign pos_m1   = pos_ff - AB'(1);
   assign par_addr = {1'b0, pos_m1[AB-1:1]};
   assign lc_idx   = {{(CB-AB){1'b0}}, pos_ff, 1'b1};
   assign rc_idx   = lc_idx + (CB+1)'(1);
   assign lc_ok    = lc_idx < {1'b0, fill_ff};
   assign rc_ok    = rc_idx < {1'b0, fill_ff};

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // port a: parent on the way up, root at extract, left child on the way down
   always_comb begin
      if (state_ff == S_UP_RD) begin
         rd_addr_a = par_addr;
      end else if (state_ff == S_X_RD) begin
         rd_addr_a = '0;
      end else begin
         rd_addr_a = lc_idx[AB-1:0];
      end
      if (state_ff == S_X_RD) begin
         rd_addr_b = fill_ff[AB-1:0];
      end else begin
         rd_addr_b = rc_idx[AB-1:0];
      end
   end

   always_comb begin
      if (state_ff == S_UP_CMP) begin
         cmp_sel = emh_pkg::CMP_UP;
      end else if (state_ff == S_DN_RIGHT) begin
         cmp_sel = emh_pkg::CMP_RIGHT;
      end else begin
         cmp_sel = emh_pkg::CMP_LEFT;
      end
   end

   emh_cmp u_cmp (
      .sel  (cmp_sel),
      .item (item_ff),
      .best (best_ff),
      .rd_a (rd_data_a),
      .rd_b (rd_data_b),
      .less (less)
   );

   emh_ram u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      pos_in     = pos_ff;
      item_in    = item_ff;
      best_in    = best_ff;
      best_lc_in = best_lc_ff;
      status_in  = status_ff;
      out_in     = out_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = item_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               out_in = '0;
               if (req_func == emh_pkg::FUNC_INSERT) begin
                  if (fill_ff == CB'(emh_pkg::CAPACITY)) begin
                     status_in = emh_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     status_in = emh_pkg::ST_INSERTED;
                     item_in   = req_entry;
                     pos_in    = fill_ff[AB-1:0];
                     fill_in   = fill_ff + CB'(1);
                     state_in  = S_UP_RD;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     status_in = emh_pkg::ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     status_in = emh_pkg::ST_EXTRACTED;
                     fill_in   = fill_ff - CB'(1);
                     state_in  = S_X_RD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (less) begin
               // parent strictly later: it drops into the hole
               wr_data  = rd_data_a;
               pos_in   = par_addr;
               state_in = S_UP_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_X_RD: begin
            state_in = S_X_GET;
         end
         S_X_GET: begin
            out_in  = rd_data_a;
            item_in = rd_data_b;
            pos_in  = '0;
            if (fill_ff == '0) begin
               state_in = S_DONE;
            end else begin
               state_in = S_DN_RD;
            end
         end
         S_DN_RD: begin
            state_in = S_DN_LEFT;
         end
         S_DN_LEFT: begin
            if (lc_ok && less) begin
               best_in    = rd_data_a;
               best_lc_in = 1'b1;
            end else begin
               best_in    = item_ff;
               best_lc_in = 1'b0;
            end
            state_in = S_DN_RIGHT;
         end
         S_DN_RIGHT: begin
            wr_en = 1'b1;
            if (rc_ok && less) begin
               wr_data  = rd_data_b;
               pos_in   = rc_idx[AB-1:0];
               state_in = S_DN_RD;
            end else if (best_lc_ff) begin
               wr_data  = best_ff;
               pos_in   = lc_idx[AB-1:0];
               state_in = S_DN_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res.valid       = (state_ff == S_DONE);
      res.status      = status_ff;
      res.out_time    = out_ff.time_val;
      res.out_kind    = out_ff.kind;
      res.entry_count = fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      pos_ff     <= pos_in;
      item_ff    <= item_in;
      best_ff    <= best_in;
      best_lc_ff <= best_lc_in;
      status_ff  <= status_in;
      out_ff     <= out_in;
   end

endmodule

/* hdl/event_min_heap.sv */
// Binary min-heap of timed events, keyed on event time (lowest time first).
// Input stream (req_): one beat is one operation. req_tuser selects insert or
// extract-min; req_tdata carries the event time and kind used by inserts.
// Result stream (rsp_): exactly one beat per operation, in order. rsp_tuser
// is the status (inserted, full and dropped, extracted, empty); rsp_tdata
// carries the extracted time and kind (zero unless extracted) and the
// number of entries held after the operation.
// Flow: the heap works on one operation at a time and holds req_tready
// low meanwhile. An insert climbs at most 10 levels for 1024 entries and
// an extract sinks the moved entry at most 9 levels, or not at all when
// the last entry leaves; each level is one pass over the dual-read entry
// RAM and the shared time comparator. Full and empty cases skip the RAM.
// The next beat can be taken in the cycle after the result is registered.
// Reset (synchronous, active high) empties the heap at once; no clear pass.
// A stalled receiver: the result sits in the output register and the next
// operation is still accepted and worked on; its result waits until the
// output register frees up, and req_tready stays low until then.
module event_min_heap (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [55:0]  req_tdata,   // [47:0] event_time, [51:48] event_kind, rest zero
   input  logic [0:0]   req_tuser,   // [0] func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // [47:0] out_time, [51:48] out_kind,
                                     // [62:52] entry_count, rest zero
   output logic [1:0]   rsp_tuser    // [1:0] status
);

   emh_pkg::result_type   res;
   emh_pkg::entry_type    req_entry;
   logic                  res_take;

   logic                  rsp_valid_ff;
   logic [63:0]           rsp_data_ff;
   logic [1:0]            rsp_user_ff;

   assign req_entry.time_val = req_tdata[emh_pkg::TIME_BITS-1:0];
   assign req_entry.kind     = req_tdata[emh_pkg::TIME_BITS +: emh_pkg::KIND_BITS];

   // output register is free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || rsp_tready;

   emh_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_func  (req_tuser[0]),
      .req_entry (req_entry),
      .res       (res),
      .res_take  (res_take)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid && res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res.valid && res_take) begin
         rsp_data_ff <= {1'b0, res.entry_count, res.out_kind, res.out_time};
         rsp_user_ff <= res.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

/* tb/tb_event_min_heap.sv */
`timescale 1ns / 1ps

module tb_event_min_heap;

   // one operation as offered on the request stream
   typedef struct {
      logic                          func;
      logic [emh_pkg::TIME_BITS-1:0] ev_time;
      logic [emh_pkg::KIND_BITS-1:0] ev_kind;
      bit                            hold;      // sender drains all results before this beat
   } op_beat_type;

   // one result beat, field by field
   typedef struct {
      logic [emh_pkg::STAT_BITS-1:0] status;
      logic [emh_pkg::TIME_BITS-1:0] out_time;
      logic [emh_pkg::KIND_BITS-1:0] out_kind;
      logic [emh_pkg::CNT_BITS-1:0]  entry_count;
   } rsp_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [55:0]  req_tdata = '0;    // [47:0] event_time, [51:48] event_kind, rest zero
   logic [0:0]   req_tuser = '0;    // [0] func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;         // [47:0] out_time, [51:48] out_kind, [62:52] entry_count
   logic [1:0]   rsp_tuser;         // [1:0] status

   event_min_heap u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Heap predictor: own copy of the entry store and fill count
   // ---------------------------------------------------------------------
   emh_pkg::entry_type heap_mem [emh_pkg::CAPACITY];
   int unsigned        heap_fill = 0;

   function automatic void heap_swap(int unsigned a, int unsigned b);
      emh_pkg::entry_type tmp;
      tmp         = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = tmp;
   endfunction

   // applies one operation to the predicted heap, returns the result beat
   function automatic rsp_beat_type heap_apply(logic func,
                                               logic [emh_pkg::TIME_BITS-1:0] t,
                                               logic [emh_pkg::KIND_BITS-1:0] k);
      rsp_beat_type r;
      int unsigned  pos, par, lc, rc, best;
      bit           settled;
      r.status   = emh_pkg::ST_INSERTED;
      r.out_time = '0;
      r.out_kind = '0;
      if (func == emh_pkg::FUNC_INSERT) begin
         if (heap_fill >= emh_pkg::CAPACITY) begin
            r.status = emh_pkg::ST_FULL;
         end else begin
            // append, then climb while the parent is strictly later
            pos = heap_fill;
            heap_fill++;
            heap_mem[pos].time_val = t;
            heap_mem[pos].kind     = k;
            settled = 1'b0;
            while (pos != 0 && !settled) begin
               par = (pos - 1) / 2;
               if (heap_mem[par].time_val > heap_mem[pos].time_val) begin
                  heap_swap(pos, par);
                  pos = par;
               end else begin
                  settled = 1'b1;
               end
            end
         end
      end else begin
         if (heap_fill == 0) begin
            r.status = emh_pkg::ST_EMPTY;
         end else begin
            r.status   = emh_pkg::ST_EXTRACTED;
            r.out_time = heap_mem[0].time_val;
            r.out_kind = heap_mem[0].kind;
            heap_fill--;
            if (heap_fill != 0) begin
               // last entry to the root, then sink; left child wins ties
               heap_mem[0] = heap_mem[heap_fill];
               pos = 0;
               settled = 1'b0;
               while (!settled) begin
                  best = pos;
                  lc   = 2 * pos + 1;
                  rc   = 2 * pos + 2;
                  if (lc < heap_fill && heap_mem[lc].time_val < heap_mem[best].time_val)
                     best = lc;
                  if (rc < heap_fill && heap_mem[rc].time_val < heap_mem[best].time_val)
                     best = rc;
                  if (best == pos) begin
                     settled = 1'b1;
                  end else begin
                     heap_swap(pos, best);
                     pos = best;
                  end
               end
            end
         end
      end
      r.entry_count = heap_fill[emh_pkg::CNT_BITS-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus store and bookkeeping
   // ---------------------------------------------------------------------
   op_beat_type  op_queue [$];      // beats not yet offered
   rsp_beat_type due_results [$];   // predicted results, oldest first
   int           error_count = 0;
   int           ops_taken = 0;
   bit           req_taken = 1'b0;  // request beat moved at the last rising edge
   int unsigned  gen_fill = 0;      // fill level the generator expects

   task automatic report_mismatch(string what);
      $display("%0t ns  MISMATCH  %s", $time, what);
      error_count++;
   endtask

   task automatic add_op(logic func, logic [emh_pkg::TIME_BITS-1:0] t,
                         logic [emh_pkg::KIND_BITS-1:0] k, bit hold = 1'b0);
      op_beat_type op;
      op.func    = func;
      op.ev_time = t;
      op.ev_kind = k;
      op.hold    = hold;
      op_queue.push_back(op);
      if (func == emh_pkg::FUNC_INSERT && gen_fill < emh_pkg::CAPACITY)
         gen_fill++;
      else if (func == emh_pkg::FUNC_EXTRACT && gen_fill > 0)
         gen_fill--;
   endtask

   // mix of extremes, tie-heavy small values and full-range values
   function automatic logic [emh_pkg::TIME_BITS-1:0] pick_time();
      logic [63:0] wide;
      logic [63:0] low_val;
      logic [63:0] top_off;
      wide    = {$urandom, $urandom};
      low_val = 64'($urandom_range(0, 15));
      top_off = 64'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return low_val[emh_pkg::TIME_BITS-1:0];
         4:       return '1 - top_off[emh_pkg::TIME_BITS-1:0];
         default: return wide[emh_pkg::TIME_BITS-1:0];
      endcase
   endfunction

   task automatic add_random(int n, int extract_pct, bit hold_first = 1'b0);
      for (int i = 0; i < n; i++)
         add_op(($urandom_range(0, 99) < extract_pct) ? emh_pkg::FUNC_EXTRACT
                                                       : emh_pkg::FUNC_INSERT,
                pick_time(), 4'($urandom_range(0, 15)), hold_first && i == 0);
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers beats at the falling edge, in bursts with gaps
   // ---------------------------------------------------------------------
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(negedge clock) begin : driver
      op_beat_type cur;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (op_queue.size() == 0 ||
                      (op_queue[0].hold && due_results.size() != 0)) begin
            // nothing left, or draining before a marked beat
            req_tvalid <= 1'b0;
         end else begin
            cur = op_queue.pop_front();
            req_tuser  <= cur.func;
            req_tdata  <= {4'b0, cur.ev_kind, cur.ev_time};
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: switches between random stall patterns; a long hold-off now
   // and then lets the heap back up and drop req_tready
   // ---------------------------------------------------------------------
   int unsigned stall_mode = 0;
   int unsigned mode_left = 0;
   int unsigned hold_left = 0;
   int          next_hold_at = 300;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_left == 0 && ops_taken >= next_hold_at) begin
            hold_left = 400;
            next_hold_at += 900;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_tready <= 1'b1;                          // no stalls
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);   // light
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);   // heavy
               default: rsp_tready <= !rsp_tready;                   // toggling
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on each accepted request, checks each result beat
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      rsp_beat_type got, want;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         due_results.push_back(heap_apply(req_tuser[0],
            req_tdata[emh_pkg::TIME_BITS-1:0],
            req_tdata[emh_pkg::TIME_BITS+emh_pkg::KIND_BITS-1:emh_pkg::TIME_BITS]));
         ops_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tuser;
         got.out_time    = rsp_tdata[47:0];
         got.out_kind    = rsp_tdata[51:48];
         got.entry_count = rsp_tdata[62:52];
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing expected, status %0d",
                                      got.status));
         end else begin
            want = due_results.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.out_time !== want.out_time)
               report_mismatch($sformatf("out_time %h, want %h",
                                         got.out_time, want.out_time));
            if (got.out_kind !== want.out_kind)
               report_mismatch($sformatf("out_kind %h, want %h",
                                         got.out_kind, want.out_kind));
            if (got.entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count %0d, want %0d",
                                         got.entry_count, want.entry_count));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: directed corners, then random phases, then end of run
   // ---------------------------------------------------------------------
   initial begin
      // directed: empty extract, extreme times and kinds
      add_op(emh_pkg::FUNC_EXTRACT, '1, 4'hF);
      add_op(emh_pkg::FUNC_INSERT, '1, 4'hF);
      add_op(emh_pkg::FUNC_INSERT, '0, 4'h0);
      add_op(emh_pkg::FUNC_INSERT, 48'h8000_0000_0000, 4'h8);
      add_op(emh_pkg::FUNC_INSERT, 48'h0000_0001_0000, 4'h7);
      // equal times: no climb past an equal parent, left child wins ties
      add_op(emh_pkg::FUNC_INSERT, 48'd5, 4'h1);
      add_op(emh_pkg::FUNC_INSERT, 48'd5, 4'h2);
      add_op(emh_pkg::FUNC_INSERT, 48'd5, 4'h3);
      add_op(emh_pkg::FUNC_INSERT, 48'd3, 4'h4);
      add_op(emh_pkg::FUNC_INSERT, 48'd5, 4'h5);
      // drain fully, including the single-entry extract, then empty again
      for (int i = 0; i < 10; i++)
         add_op(emh_pkg::FUNC_EXTRACT, '0, '0);
      add_op(emh_pkg::FUNC_INSERT, 48'h5555_5555_5555, 4'hA);
      add_op(emh_pkg::FUNC_EXTRACT, 48'hAAAA_AAAA_AAAA, 4'h5);
      add_op(emh_pkg::FUNC_EXTRACT, '0, '0);

      // random mix; sender drains before it starts
      add_random(250, 40, 1'b1);

      // fill to capacity with a few extracts mixed in
      op_queue.push_back('{emh_pkg::FUNC_INSERT, pick_time(),
                           4'($urandom_range(0, 15)), 1'b1});
      gen_fill++;
      while (gen_fill < emh_pkg::CAPACITY)
         add_op(($urandom_range(0, 99) < 6) ? emh_pkg::FUNC_EXTRACT : emh_pkg::FUNC_INSERT,
                pick_time(), 4'($urandom_range(0, 15)));
      // inserts against a full heap, one slot freed and refilled
      for (int i = 0; i < 4; i++)
         add_op(emh_pkg::FUNC_INSERT, pick_time(), 4'($urandom_range(0, 15)));
      add_op(emh_pkg::FUNC_EXTRACT, '0, '0);
      add_op(emh_pkg::FUNC_INSERT, '0, 4'hF);
      add_op(emh_pkg::FUNC_INSERT, '1, 4'h0);

      // churn near full, partial drain, random tail
      add_random(100, 50);
      add_random(300, 85);
      add_random(150, 50);

      while (reset) @(posedge clock);
      while (op_queue.size() != 0 || req_tvalid || due_results.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (due_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", due_results.size()));
      if (error_count == 0)
         $display("tb_event_min_heap: done, clean");
      else
         $display("tb_event_min_heap: done, errors");
      $finish;
   end

   // reset: synchronous, asserted from the start, released at a falling edge
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("tb_event_min_heap: done, errors");
      $finish;
   end

endmodule

/* event_min_heap.f */
hdl/emh_pkg.sv
hdl/emh_ram.sv
hdl/emh_cmp.sv
hdl/emh_seq.sv
hdl/event_min_heap.sv
tb/tb_event_min_heap.sv
